>>> hw/rtl/fssp_pkg.sv
// ----------------------------------------------------------------------------
// fssp_pkg
// Shared widths, codes and helpers for the feed-scaled spindle PWM block.
// ----------------------------------------------------------------------------
package fssp_pkg;

	localparam int TICK_BITS = 20;
	localparam int FRAC_BITS = 16;
	localparam int SPD_W     = 16;
	localparam int POS_W     = TICK_BITS + 1;
	localparam int POW_W     = FRAC_BITS + 1;
	localparam int DLT_W     = FRAC_BITS + 2;
	localparam int MC_W      = POW_W + TICK_BITS;
	localparam int PROD_W    = MC_W + SPD_W;
	localparam int DVD_W     = PROD_W - FRAC_BITS;
	localparam int QUO_W     = POS_W;
	localparam int CNT_W     = $clog2(DVD_W + 1);

	localparam int IN_BITS   = 112;
	localparam int OUT_BITS  = 48;

	localparam logic [POW_W-1:0] POWER_ONE = POW_W'(1) << FRAC_BITS;
	localparam logic [POW_W-1:0] POWER_MAX = '1;

	localparam int RST_PERIOD = 1000;
	localparam int RST_SPEED  = 4000;
	localparam int RST_MAX    = 5000;
	localparam int RST_THR    = (RST_PERIOD * RST_SPEED) / RST_MAX;

	typedef enum logic [1:0] {
		REG_PERIOD,
		REG_SPEED,
		REG_MAX,
		REG_DYNAMIC
	} cfg_reg_t;

	localparam logic [1:0] PH_ACCEL = 2'd0;
	localparam logic [1:0] PH_DECEL = 2'd2;

	localparam logic CMD_SEGMENT = 1'b0;
	localparam logic CMD_EDGE    = 1'b1;

	function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
		input logic [POS_W-1:0] b);
		logic [POS_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
	endfunction

	function automatic logic [POW_W-1:0] sat_pow(input logic [QUO_W-1:0] q, input logic ovf);
		if (ovf || (q > QUO_W'(POWER_MAX))) begin
			return POWER_MAX;
		end
		return q[POW_W-1:0];
	endfunction

	function automatic logic [POW_W-1:0] clamp_pow(input logic signed [DLT_W:0] v);
		if (v < 0) begin
			return '0;
		end
		if (v > $signed((DLT_W+1)'(POWER_MAX))) begin
			return POWER_MAX;
		end
		return v[POW_W-1:0];
	endfunction

endpackage

>>> hw/rtl/feed_scaled_spindle_pwm_top.sv
// ----------------------------------------------------------------------------
// feed_scaled_spindle_pwm_top
// Edge-scheduled spindle PWM whose duty follows motion segment progress.
// ----------------------------------------------------------------------------
// Each input word yields one output word, and the input is ready again in the
// cycle after the output word is registered. An edge word with no ramp to
// follow goes straight to S_DONE; a segment-start word with dynamic power off
// passes S_SEG_FIN and S_DONE. Work on a ramp runs on one bit-serial shift-add
// multiplier and one restoring divider, one bit per cycle. An edge word inside
// a ramp runs S_MUL_I and S_DIV_I, then S_MUL_P, S_MUL_S and S_DIV_T, and once
// the ramp is complete only the latter; a cruise segment start runs them and
// S_SEG_FIN, one on a ramp S_RAT_A and S_RAT_B first. An output word not taken
// holds the block in S_DONE. A speed register write recomputes the threshold in
// the S_MUL_P, S_MUL_S and S_DIV_T states, during which no input word is taken.
module feed_scaled_spindle_pwm_top
	import fssp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// Low bit up: phase[2], entry_rate[16], peak_rate[16], leave_rate[16],
	// target_rate[16], ramp_up_ticks[20], ramp_down_ticks[20], zero pad.
	input  logic [IN_BITS-1:0]  s_axis_tdata,
	// command: 0 segment start, 1 PWM edge.
	input  logic                s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// Low bit up: next_interval[20], pwm_level[1], duty_threshold[20], zero pad.
	output logic [OUT_BITS-1:0] m_axis_tdata,
	input  logic                cfg_wen,
	input  logic [1:0]          cfg_index,
	input  logic [TICK_BITS-1:0] cfg_wdata
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RAT_A,
		S_RAT_B,
		S_MUL_P,
		S_MUL_S,
		S_DIV_T,
		S_MUL_I,
		S_DIV_I,
		S_SEG_FIN,
		S_DONE
	} state_t;

	localparam int OUT_PAD = OUT_BITS - (2 * TICK_BITS + 1);

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    cfg_job_q;
	logic                    cmd_q;

	logic [TICK_BITS-1:0]    period_q;
	logic [SPD_W-1:0]        speed_q;
	logic [SPD_W-1:0]        max_q;
	logic                    dyn_q;

	logic [POS_W-1:0]        pos_q;
	logic [TICK_BITS-1:0]    thr_q;
	logic [POS_W-1:0]        elapsed_q;
	logic [POW_W-1:0]        pstart_q;
	logic signed [DLT_W-1:0] pdelta_q;
	logic                    level_q;
	logic [TICK_BITS-1:0]    t_q;

	logic [TICK_BITS-1:0]    per_op_q;
	logic [SPD_W-1:0]        spd_op_q;
	logic [SPD_W-1:0]        max_op_q;
	logic [SPD_W-1:0]        rate_b_q;

	logic [PROD_W-1:0]       acc_q;
	logic [MC_W-1:0]         mcand_q;
	logic [TICK_BITS-1:0]    mplier_q;
	logic [DVD_W-1:0]        dvd_q;
	logic [TICK_BITS-1:0]    dvs_q;
	logic [TICK_BITS-1:0]    rem_q;
	logic [QUO_W-1:0]        quo_q;
	logic                    ovf_q;

	logic                    out_valid_q;
	logic [TICK_BITS-1:0]    out_t_q;
	logic                    out_level_q;
	logic [TICK_BITS-1:0]    out_thr_q;

	logic [IN_BITS-1:0]      din;
	logic [1:0]              in_phase;
	logic [SPD_W-1:0]        in_entry;
	logic [SPD_W-1:0]        in_peak;
	logic [SPD_W-1:0]        in_leave;
	logic [SPD_W-1:0]        in_target;
	logic [TICK_BITS-1:0]    in_up;
	logic [TICK_BITS-1:0]    in_down;
	logic                    in_ramp;
	logic [TICK_BITS-1:0]    in_ticks;
	logic                    in_full;

	logic [PROD_W-1:0]       acc_step;
	logic [TICK_BITS:0]      rem_try;
	logic                    rem_ge;
	logic [TICK_BITS-1:0]    rem_nxt;
	logic [QUO_W-1:0]        quo_nxt;
	logic                    ovf_nxt;
	logic                    step_last;
	logic [POW_W-1:0]        ratio_nxt;
	logic [TICK_BITS-1:0]    thr_fin;

	logic [SPD_W-1:0]        spd_clamp;
	logic [POW_W-1:0]        dabs;
	logic [POW_W-1:0]        pow_end;
	logic [POW_W-1:0]        pow_interp;
	logic signed [DLT_W:0]   pdelta_ext;

	logic                    edge_wrap;
	logic [TICK_BITS-1:0]    edge_t;
	logic [TICK_BITS-1:0]    seg_t;
	logic                    seg_level;
	logic                    accept;

	assign din       = s_axis_tdata;
	assign in_phase  = din[1:0];
	assign in_entry  = din[17:2];
	assign in_peak   = din[33:18];
	assign in_leave  = din[49:34];
	assign in_target = din[65:50];
	assign in_up     = din[85:66];
	assign in_down   = din[105:86];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_thr_q, out_level_q, out_t_q};

	always_comb begin
		in_ramp   = dyn_q && ((in_phase == PH_ACCEL) || (in_phase == PH_DECEL));
		in_ticks  = (in_phase == PH_ACCEL) ? in_up : in_down;
		in_full   = (in_ticks == '0) || (elapsed_q >= {1'b0, in_ticks});
		spd_clamp = (speed_q < max_q) ? speed_q : max_q;

		acc_step  = {acc_q[PROD_W-2:0], 1'b0} +
			(mplier_q[TICK_BITS-1] ? PROD_W'(mcand_q) : PROD_W'(0));
		rem_try   = {rem_q, dvd_q[DVD_W-1]};
		rem_ge    = rem_try >= {1'b0, dvs_q};
		rem_nxt   = rem_ge ? TICK_BITS'(rem_try - {1'b0, dvs_q}) : rem_try[TICK_BITS-1:0];
		quo_nxt   = {quo_q[QUO_W-2:0], rem_ge};
		ovf_nxt   = ovf_q | quo_q[QUO_W-1];
		step_last = (cnt_q == CNT_W'(1));
		ratio_nxt = sat_pow(quo_nxt, ovf_nxt);

		if (max_op_q == '0) begin
			thr_fin = '0;
		end else if (ovf_nxt || (quo_nxt > {1'b0, per_op_q})) begin
			thr_fin = per_op_q;
		end else begin
			thr_fin = quo_nxt[TICK_BITS-1:0];
		end

		pdelta_ext = {pdelta_q[DLT_W-1], pdelta_q};
		dabs       = pdelta_q[DLT_W-1] ? POW_W'(-pdelta_q) : POW_W'(pdelta_q);
		pow_end    = clamp_pow($signed({2'b00, pstart_q}) + pdelta_ext);
		if (pdelta_q[DLT_W-1]) begin
			pow_interp = clamp_pow($signed({2'b00, pstart_q}) -
				$signed({2'b00, quo_nxt[POW_W-1:0]}));
		end else begin
			pow_interp = clamp_pow($signed({2'b00, pstart_q}) +
				$signed({2'b00, quo_nxt[POW_W-1:0]}));
		end

		edge_wrap = pos_q >= {1'b0, period_q};
		if (edge_wrap) begin
			edge_t = thr_q;
		end else if (period_q > thr_q) begin
			edge_t = period_q - thr_q;
		end else begin
			edge_t = '0;
		end

		if (pos_q < {1'b0, thr_q}) begin
			seg_t     = thr_q - pos_q[TICK_BITS-1:0];
			seg_level = 1'b1;
		end else if (pos_q < {1'b0, period_q}) begin
			seg_t     = period_q - pos_q[TICK_BITS-1:0];
			seg_level = 1'b0;
		end else begin
			seg_t     = '0;
			seg_level = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			cfg_job_q   <= 1'b0;
			cmd_q       <= CMD_SEGMENT;
			period_q    <= TICK_BITS'(RST_PERIOD);
			speed_q     <= SPD_W'(RST_SPEED);
			max_q       <= SPD_W'(RST_MAX);
			dyn_q       <= 1'b1;
			pos_q       <= '0;
			thr_q       <= TICK_BITS'(RST_THR);
			elapsed_q   <= '0;
			pstart_q    <= '0;
			pdelta_q    <= '0;
			level_q     <= 1'b0;
			t_q         <= '0;
			per_op_q    <= '0;
			spd_op_q    <= '0;
			max_op_q    <= '0;
			rate_b_q    <= '0;
			acc_q       <= '0;
			mcand_q     <= '0;
			mplier_q    <= '0;
			dvd_q       <= '0;
			dvs_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_t_q     <= '0;
			out_level_q <= 1'b0;
			out_thr_q   <= '0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q     <= s_axis_tuser;
						cfg_job_q <= 1'b0;
						per_op_q  <= period_q;
						spd_op_q  <= spd_clamp;
						max_op_q  <= max_q;
						acc_q     <= '0;
						if (s_axis_tuser == CMD_EDGE) begin
							t_q       <= edge_t;
							level_q   <= edge_wrap;
							pos_q     <= sat_add(edge_wrap ? '0 : pos_q, {1'b0, edge_t});
							elapsed_q <= sat_add(elapsed_q, {1'b0, edge_t});
							if (!in_ramp) begin
								state_q <= S_DONE;
							end else if (in_full) begin
								mcand_q  <= MC_W'(pow_end);
								mplier_q <= period_q;
								cnt_q    <= CNT_W'(TICK_BITS);
								state_q  <= S_MUL_P;
							end else begin
								mcand_q  <= MC_W'(dabs);
								mplier_q <= elapsed_q[TICK_BITS-1:0];
								dvs_q    <= in_ticks;
								cnt_q    <= CNT_W'(TICK_BITS);
								state_q  <= S_MUL_I;
							end
						end else begin
							if (!dyn_q) begin
								state_q <= S_SEG_FIN;
							end else if (in_ramp) begin
								dvd_q    <= DVD_W'({(in_phase == PH_ACCEL) ? in_entry : in_peak,
									{FRAC_BITS{1'b0}}});
								rate_b_q <= (in_phase == PH_ACCEL) ? in_peak : in_leave;
								dvs_q    <= TICK_BITS'(in_target);
								rem_q    <= '0;
								quo_q    <= '0;
								ovf_q    <= 1'b0;
								cnt_q    <= CNT_W'(DVD_W);
								state_q  <= S_RAT_A;
							end else begin
								mcand_q  <= MC_W'(POWER_ONE);
								mplier_q <= period_q;
								cnt_q    <= CNT_W'(TICK_BITS);
								state_q  <= S_MUL_P;
							end
						end
					end
				end
				S_RAT_A: begin
					dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
					rem_q <= rem_nxt;
					quo_q <= quo_nxt;
					ovf_q <= ovf_nxt;
					cnt_q <= cnt_q - CNT_W'(1);
					if (step_last) begin
						pstart_q <= ratio_nxt;
						dvd_q    <= DVD_W'({rate_b_q, {FRAC_BITS{1'b0}}});
						rem_q    <= '0;
						quo_q    <= '0;
						ovf_q    <= 1'b0;
						cnt_q    <= CNT_W'(DVD_W);
						state_q  <= S_RAT_B;
					end
				end
				S_RAT_B: begin
					dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
					rem_q <= rem_nxt;
					quo_q <= quo_nxt;
					ovf_q <= ovf_nxt;
					cnt_q <= cnt_q - CNT_W'(1);
					if (step_last) begin
						pdelta_q <= $signed({1'b0, ratio_nxt}) - $signed({1'b0, pstart_q});
						mcand_q  <= MC_W'(pstart_q);
						mplier_q <= per_op_q;
						acc_q    <= '0;
						cnt_q    <= CNT_W'(TICK_BITS);
						state_q  <= S_MUL_P;
					end
				end
				S_MUL_P: begin
					acc_q    <= acc_step;
					mplier_q <= {mplier_q[TICK_BITS-2:0], 1'b0};
					cnt_q    <= cnt_q - CNT_W'(1);
					if (step_last) begin
						mcand_q  <= acc_step[MC_W-1:0];
						mplier_q <= TICK_BITS'(spd_op_q);
						acc_q    <= '0;
						cnt_q    <= CNT_W'(TICK_BITS);
						state_q  <= S_MUL_S;
					end
				end
				S_MUL_S: begin
					acc_q    <= acc_step;
					mplier_q <= {mplier_q[TICK_BITS-2:0], 1'b0};
					cnt_q    <= cnt_q - CNT_W'(1);
					if (step_last) begin
						dvd_q   <= acc_step[PROD_W-1:FRAC_BITS];
						dvs_q   <= TICK_BITS'(max_op_q);
						rem_q   <= '0;
						quo_q   <= '0;
						ovf_q   <= 1'b0;
						cnt_q   <= CNT_W'(DVD_W);
						state_q <= S_DIV_T;
					end
				end
				S_DIV_T: begin
					dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
					rem_q <= rem_nxt;
					quo_q <= quo_nxt;
					ovf_q <= ovf_nxt;
					cnt_q <= cnt_q - CNT_W'(1);
					if (step_last) begin
						thr_q <= thr_fin;
						if (cfg_job_q) begin
							state_q <= S_IDLE;
						end else if (cmd_q == CMD_SEGMENT) begin
							state_q <= S_SEG_FIN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_MUL_I: begin
					acc_q    <= acc_step;
					mplier_q <= {mplier_q[TICK_BITS-2:0], 1'b0};
					cnt_q    <= cnt_q - CNT_W'(1);
					if (step_last) begin
						dvd_q   <= acc_step[DVD_W-1:0];
						rem_q   <= '0;
						quo_q   <= '0;
						ovf_q   <= 1'b0;
						cnt_q   <= CNT_W'(DVD_W);
						state_q <= S_DIV_I;
					end
				end
				S_DIV_I: begin
					dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
					rem_q <= rem_nxt;
					quo_q <= quo_nxt;
					ovf_q <= ovf_nxt;
					cnt_q <= cnt_q - CNT_W'(1);
					if (step_last) begin
						mcand_q  <= MC_W'(pow_interp);
						mplier_q <= per_op_q;
						acc_q    <= '0;
						cnt_q    <= CNT_W'(TICK_BITS);
						state_q  <= S_MUL_P;
					end
				end
				S_SEG_FIN: begin
					t_q       <= seg_t;
					level_q   <= seg_level;
					elapsed_q <= {1'b0, seg_t};
					pos_q     <= sat_add(pos_q, {1'b0, seg_t});
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_t_q     <= t_q;
						out_level_q <= level_q;
						out_thr_q   <= thr_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cfg_wen) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_PERIOD: begin
						period_q <= cfg_wdata;
					end
					REG_SPEED: begin
						speed_q   <= cfg_wdata[SPD_W-1:0];
						cfg_job_q <= 1'b1;
						per_op_q  <= period_q;
						max_op_q  <= max_q;
						spd_op_q  <= (cfg_wdata[SPD_W-1:0] < max_q) ? cfg_wdata[SPD_W-1:0] : max_q;
						mcand_q   <= MC_W'(POWER_ONE);
						mplier_q  <= period_q;
						acc_q     <= '0;
						cnt_q     <= CNT_W'(TICK_BITS);
						state_q   <= S_MUL_P;
					end
					REG_MAX: begin
						max_q <= cfg_wdata[SPD_W-1:0];
					end
					REG_DYNAMIC: begin
						dyn_q <= cfg_wdata[0];
					end
					default: begin
						dyn_q <= dyn_q;
					end
				endcase
			end
		end
	end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the feed-scaled spindle PWM block. A short table of
// directed words is followed by mostly ramp-shaped segment traffic under
// several register settings. Output words are compared with typed table rows or
// an in-bench model of the edge scheduler and the ramp power interpolation.
// ----------------------------------------------------------------------------
module testbench
	import fssp_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] PH_CRUISE = 2'd1;
	localparam logic [1:0] PH_SPARE  = 2'd3;

	localparam int N_DIRECTED      = 23;
	localparam int N_PHASES        = 8;
	localparam int ITEMS_PER_PHASE = 235;
	localparam int LONG_HOLD       = 1500;
	localparam int STALL_LIMIT     = 20000;
	localparam int TAIL_CYCLES     = 200;

	typedef struct packed {
		logic                 cmd;
		logic [1:0]           phase;
		logic [SPD_W-1:0]     entry;
		logic [SPD_W-1:0]     peak;
		logic [SPD_W-1:0]     leave;
		logic [SPD_W-1:0]     target;
		logic [TICK_BITS-1:0] up;
		logic [TICK_BITS-1:0] down;
	} seg_word_t;

	typedef struct packed {
		logic [TICK_BITS-1:0] interval;
		logic                 level;
		logic [TICK_BITS-1:0] thr;
	} edge_word_t;

	typedef struct packed {
		seg_word_t  w;
		logic       typed;
		edge_word_t r;
	} stim_row_t;

	typedef struct packed {
		logic [TICK_BITS-1:0] period;
		logic [SPD_W-1:0]     speed;
		logic [SPD_W-1:0]     top_speed;
		logic                 dyn;
		logic                 speed_write;
	} spindle_cfg_t;

	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{'{CMD_EDGE,    PH_CRUISE, 16'd0, 16'd0, 16'd0, 16'd1, 20'd0, 20'd0},
			1'b1, '{20'd200, 1'b0, 20'd800}},
		'{'{CMD_SEGMENT, PH_CRUISE, 16'd0, 16'd0, 16'd0, 16'd1, 20'd0, 20'd0},
			1'b1, '{20'd600, 1'b1, 20'd800}},
		'{'{CMD_EDGE,    PH_CRUISE, 16'd0, 16'd0, 16'd0, 16'd1, 20'd0, 20'd0},
			1'b1, '{20'd200, 1'b0, 20'd800}},
		'{'{CMD_EDGE,    PH_CRUISE, 16'd0, 16'd0, 16'd0, 16'd1, 20'd0, 20'd0},
			1'b1, '{20'd800, 1'b1, 20'd800}},
		'{'{CMD_SEGMENT, PH_ACCEL, 16'd0, 16'hFFFF, 16'd0, 16'd1, 20'd0, 20'd0},
			1'b1, '{20'd200, 1'b0, 20'd0}},
		'{'{CMD_EDGE,    PH_ACCEL, 16'd0, 16'hFFFF, 16'd0, 16'd1, 20'd0, 20'd0},
			1'b1, '{20'd0, 1'b1, 20'd1000}},
		'{'{CMD_EDGE,    PH_ACCEL, 16'd0, 16'hFFFF, 16'd0, 16'd1, 20'd0, 20'd0},
			1'b0, '0},
		'{'{CMD_SEGMENT, PH_DECEL, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 20'd0, 20'hFFFFF},
			1'b0, '0},
		'{'{CMD_EDGE,    PH_DECEL, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 20'd0, 20'hFFFFF},
			1'b0, '0},
		'{'{CMD_EDGE,    PH_DECEL, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 20'd0, 20'hFFFFF},
			1'b0, '0},
		'{'{CMD_EDGE,    PH_DECEL, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 20'd0, 20'hFFFFF},
			1'b0, '0},
		'{'{CMD_SEGMENT, PH_ACCEL, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 20'd5000, 20'd0},
			1'b0, '0},
		'{'{CMD_EDGE,    PH_ACCEL, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 20'd5000, 20'd0},
			1'b0, '0},
		'{'{CMD_SEGMENT, PH_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			20'hFFFFF, 20'hFFFFF}, 1'b0, '0},
		'{'{CMD_EDGE,    PH_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			20'hFFFFF, 20'hFFFFF}, 1'b0, '0},
		'{'{CMD_SEGMENT, PH_ACCEL, 16'd1000, 16'd3000, 16'd0, 16'd4000, 20'd3000, 20'd0},
			1'b0, '0},
		'{'{CMD_EDGE,    PH_ACCEL, 16'd1000, 16'd3000, 16'd0, 16'd4000, 20'd3000, 20'd0},
			1'b0, '0},
		'{'{CMD_EDGE,    PH_ACCEL, 16'd1000, 16'd3000, 16'd0, 16'd4000, 20'd3000, 20'd0},
			1'b0, '0},
		'{'{CMD_EDGE,    PH_ACCEL, 16'd1000, 16'd3000, 16'd0, 16'd4000, 20'd3000, 20'd0},
			1'b0, '0},
		'{'{CMD_EDGE,    PH_ACCEL, 16'd1000, 16'd3000, 16'd0, 16'd4000, 20'd3000, 20'd0},
			1'b0, '0},
		'{'{CMD_SEGMENT, PH_DECEL, 16'd0, 16'd40000, 16'd10000, 16'd20000, 20'd0, 20'd0},
			1'b0, '0},
		'{'{CMD_EDGE,    PH_DECEL, 16'd0, 16'd40000, 16'd10000, 16'd20000, 20'd0, 20'd0},
			1'b0, '0},
		'{'{CMD_EDGE,    PH_CRUISE, 16'd0, 16'd0, 16'd0, 16'd1, 20'd0, 20'd0},
			1'b0, '0}
	};

	localparam spindle_cfg_t PHASES [N_PHASES] = '{
		'{20'd20000,   16'd30000, 16'd40000, 1'b1, 1'b1},
		'{20'd1,       16'hFFFF,  16'd1,     1'b1, 1'b1},
		'{20'hFFFFF,   16'hFFFF,  16'hFFFF,  1'b1, 1'b1},
		'{20'd5000,    16'd0,     16'd1000,  1'b1, 1'b1},
		'{20'd3000,    16'd5000,  16'd2000,  1'b0, 1'b1},
		'{20'd700,     16'd1200,  16'd60000, 1'b0, 1'b0},
		'{20'd50,      16'd100,   16'd200,   1'b1, 1'b0},
		'{20'd4096,    16'd2500,  16'd5000,  1'b1, 1'b1}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [IN_BITS-1:0]   s_axis_tdata;
	logic                 s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_BITS-1:0]  m_axis_tdata;
	logic                 cfg_wen;
	logic [1:0]           cfg_index;
	logic [TICK_BITS-1:0] cfg_wdata;

	logic [TICK_BITS-1:0] m_period = TICK_BITS'(RST_PERIOD);
	logic [SPD_W-1:0]     m_speed  = SPD_W'(RST_SPEED);
	logic [SPD_W-1:0]     m_top    = SPD_W'(RST_MAX);
	logic                 m_dyn    = 1'b1;
	logic [POS_W-1:0]     m_pos    = '0;
	logic [TICK_BITS-1:0] m_thr    = TICK_BITS'(RST_THR);
	logic [POS_W-1:0]     m_elapsed = '0;
	logic [POW_W-1:0]     m_pstart = '0;
	longint               m_pdelta = 0;
	logic                 m_level  = 1'b0;

	edge_word_t expected_q[$];
	int         mismatch_count = 0;
	int         stall_cycles = 0;
	logic       tx_idle_on;
	logic       rx_idle_on;
	logic       hold_request;

	feed_scaled_spindle_pwm_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [POW_W-1:0] speed_ratio(input logic [SPD_W-1:0] rate,
		input logic [SPD_W-1:0] tgt);
		longint unsigned q;
		if (tgt == 0) begin
			return POWER_MAX;
		end
		q = 64'(rate);
		q = (q << FRAC_BITS) / 64'(tgt);
		return (q > 64'(POWER_MAX)) ? POWER_MAX : q[POW_W-1:0];
	endfunction

	function automatic logic [TICK_BITS-1:0] duty_for(input logic [POW_W-1:0] power);
		longint unsigned spd;
		longint unsigned v;
		spd = 64'((m_speed < m_top) ? m_speed : m_top);
		if (m_top == 0) begin
			return '0;
		end
		v = 64'(power);
		v = ((v * 64'(m_period) * spd) / 64'(m_top)) >> FRAC_BITS;
		return (v > 64'(m_period)) ? m_period : v[TICK_BITS-1:0];
	endfunction

	function automatic logic [POW_W-1:0] ramp_power(input logic [POS_W-1:0] elapsed,
		input logic [TICK_BITS-1:0] ticks);
		longint          s;
		longint          p;
		longint unsigned ad;
		longint unsigned mag;
		s = longint'(m_pstart);
		if (ticks == 0 || elapsed >= {1'b0, ticks}) begin
			p = s + m_pdelta;
		end else begin
			ad = unsigned'((m_pdelta < 0) ? -m_pdelta : m_pdelta);
			mag = (ad * 64'(elapsed)) / 64'(ticks);
			p = (m_pdelta < 0) ? s - longint'(mag) : s + longint'(mag);
		end
		if (p < 0) begin
			p = 0;
		end
		return (p > longint'(POWER_MAX)) ? POWER_MAX : p[POW_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] add_sat(input logic [POS_W-1:0] a,
		input logic [POS_W-1:0] b);
		longint unsigned s;
		s = 64'(a);
		s = s + 64'(b);
		return (s > 64'({POS_W{1'b1}})) ? {POS_W{1'b1}} : s[POS_W-1:0];
	endfunction

	function automatic edge_word_t schedule_edge(input seg_word_t w);
		edge_word_t       r;
		logic [POS_W-1:0] t;
		logic [POW_W-1:0] pend;
		logic             ramp;
		ramp = (w.phase == PH_ACCEL) || (w.phase == PH_DECEL);
		if (w.cmd == CMD_SEGMENT) begin
			if (m_dyn) begin
				if (ramp) begin
					m_pstart = speed_ratio((w.phase == PH_ACCEL) ? w.entry : w.peak, w.target);
					pend = speed_ratio((w.phase == PH_ACCEL) ? w.peak : w.leave, w.target);
					m_pdelta = longint'(pend) - longint'(m_pstart);
					m_thr = duty_for(m_pstart);
				end else begin
					m_thr = duty_for(POWER_ONE);
				end
			end
			if (m_pos < {1'b0, m_thr}) begin
				t = {1'b0, m_thr} - m_pos;
				m_level = 1'b1;
			end else begin
				t = (m_pos < {1'b0, m_period}) ? {1'b0, m_period} - m_pos : '0;
				m_level = 1'b0;
			end
			m_elapsed = t;
			m_pos = add_sat(m_pos, t);
		end else begin
			if (m_pos >= {1'b0, m_period}) begin
				m_pos = '0;
				t = {1'b0, m_thr};
				m_level = 1'b1;
			end else begin
				t = (m_period > m_thr) ? {1'b0, m_period - m_thr} : '0;
				m_level = 1'b0;
			end
			if (m_dyn && ramp) begin
				m_thr = duty_for(ramp_power(m_elapsed, (w.phase == PH_ACCEL) ? w.up : w.down));
			end
			m_elapsed = add_sat(m_elapsed, t);
			m_pos = add_sat(m_pos, t);
		end
		r.interval = t[TICK_BITS-1:0];
		r.level = m_level;
		r.thr = m_thr;
		return r;
	endfunction

	function automatic void apply_reg(input cfg_reg_t idx, input logic [TICK_BITS-1:0] val);
		case (idx)
			REG_PERIOD: m_period = val;
			REG_SPEED: begin
				m_speed = val[SPD_W-1:0];
				m_thr = duty_for(POWER_ONE);
			end
			REG_MAX: m_top = val[SPD_W-1:0];
			REG_DYNAMIC: m_dyn = val[0];
			default: ;
		endcase
	endfunction

	function automatic logic [SPD_W-1:0] rate_near(input logic [SPD_W-1:0] tgt);
		int hi;
		hi = int'(tgt) + int'(tgt) / 2;
		if (hi > 65535) begin
			hi = 65535;
		end
		return SPD_W'($urandom_range(0, hi));
	endfunction

	function automatic logic [TICK_BITS-1:0] pick_ticks();
		longint unsigned span;
		span = 64'(m_period);
		span = span * 3;
		if (span > 64'(20'hFFFFF)) begin
			span = 64'(20'hFFFFF);
		end
		case ($urandom_range(0, 5))
			0: return '0;
			1: return TICK_BITS'($urandom_range(0, 20'hFFFFF));
			default: return TICK_BITS'($urandom_range(0, int'(span)));
		endcase
	endfunction

	task automatic push_word(input seg_word_t w, input logic typed, input edge_word_t typed_r);
		edge_word_t r;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= w.cmd;
		s_axis_tdata  <= IN_BITS'({w.down, w.up, w.target, w.leave, w.peak, w.entry, w.phase});
		do @(posedge clk); while (!s_axis_tready);
		r = schedule_edge(w);
		expected_q.push_back(typed ? typed_r : r);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [TICK_BITS-1:0] val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		apply_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic segment_traffic(input int n);
		int        sent;
		int        edges;
		int        pick;
		seg_word_t w;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 9) < 8) begin
				pick = $urandom_range(0, 6);
				w.cmd = CMD_SEGMENT;
				w.phase = (pick < 3) ? PH_ACCEL : ((pick == 3) ? PH_CRUISE : PH_DECEL);
				w.target = SPD_W'($urandom_range(1, 65535));
				w.entry = rate_near(w.target);
				w.peak = rate_near(w.target);
				w.leave = rate_near(w.target);
				w.up = pick_ticks();
				w.down = pick_ticks();
				push_word(w, 1'b0, '0);
				sent++;
				w.cmd = CMD_EDGE;
				edges = $urandom_range(1, 10);
				repeat (edges) begin
					push_word(w, 1'b0, '0);
					sent++;
				end
			end else begin
				w.cmd = 1'($urandom_range(0, 1));
				w.phase = 2'($urandom_range(0, 3));
				w.entry = SPD_W'($urandom_range(0, 65535));
				w.peak = SPD_W'($urandom_range(0, 65535));
				w.leave = SPD_W'($urandom_range(0, 65535));
				w.target = SPD_W'($urandom_range(1, 65535));
				w.up = TICK_BITS'($urandom_range(0, 20'hFFFFF));
				w.down = TICK_BITS'($urandom_range(0, 20'hFFFFF));
				push_word(w, 1'b0, '0);
				sent++;
			end
		end
	endtask

	initial begin
		int hold_len;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				hold_len = LONG_HOLD;
			end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				hold_len = $urandom_range(1, 12);
			end else begin
				m_axis_tready <= 1'b1;
				hold_len = $urandom_range(1, 24);
			end
			repeat (hold_len) @(negedge clk);
		end
	end

	always @(posedge clk) begin : check_words
		edge_word_t want;
		edge_word_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.interval = m_axis_tdata[TICK_BITS-1:0];
			got.level    = m_axis_tdata[TICK_BITS];
			got.thr      = m_axis_tdata[2*TICK_BITS:TICK_BITS+1];
			if (expected_q.size() == 0) begin
				mismatch_count++;
				$display("%0t unexpected word: expected none, actual %h", $time, got);
			end else begin
				want = expected_q.pop_front();
				if (got.interval !== want.interval) begin
					mismatch_count++;
					$display("%0t next_interval: expected %0d, actual %0d",
						$time, want.interval, got.interval);
				end
				if (got.level !== want.level) begin
					mismatch_count++;
					$display("%0t pwm_level: expected %0d, actual %0d",
						$time, want.level, got.level);
				end
				if (got.thr !== want.thr) begin
					mismatch_count++;
					$display("%0t duty_threshold: expected %0d, actual %0d",
						$time, want.thr, got.thr);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles == STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int k;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_SEGMENT;
		cfg_wen = 1'b0;
		cfg_index = REG_PERIOD;
		cfg_wdata = '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		hold_request = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (k = 0; k < N_DIRECTED; k++) begin
			push_word(DIRECTED_ROWS[k].w, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].r);
		end
		for (k = 0; k < N_PHASES; k++) begin
			s_axis_tvalid <= 1'b0;
			while (expected_q.size() != 0) @(posedge clk);
			@(negedge clk);
			write_reg(REG_PERIOD, PHASES[k].period);
			write_reg(REG_MAX, TICK_BITS'(PHASES[k].top_speed));
			write_reg(REG_DYNAMIC, TICK_BITS'(PHASES[k].dyn));
			if (PHASES[k].speed_write) begin
				write_reg(REG_SPEED, TICK_BITS'(PHASES[k].speed));
			end
			cfg_wen <= 1'b0;
			if (k == 1) begin
				hold_request = 1'b1;
			end
			if (k == N_PHASES - 1) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end
			segment_traffic(ITEMS_PER_PHASE);
		end
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
